// ===== src/dts_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Date-to-seconds package
// Beat types, calendar constants and the month table for the date and time
// to seconds converter.
// ----------------------------------------------------------------------------
package dts_pkg;

  localparam int unsigned YearW   = 7;
  localparam int unsigned MonthW  = 4;
  localparam int unsigned DayW    = 5;
  localparam int unsigned HourW   = 5;
  localparam int unsigned MinuteW = 6;
  localparam int unsigned SecondW = 6;
  localparam int unsigned ResultW = 32;

  // Day count and seconds of day both fit in 17 bits; the day count is
  // two's complement so that day zero of the first month gives minus one.
  localparam int unsigned DaysW = 17;
  localparam int unsigned SodW  = 17;

  localparam int unsigned DaysPerYear    = 365;
  localparam int unsigned SecondsPerDay  = 86400;
  localparam int unsigned SecondsPerHour = 3600;
  localparam int unsigned SecondsPerMin  = 60;
  localparam int unsigned MonthsPerYear  = 12;
  localparam int unsigned CenturyYear    = 100;

  localparam int unsigned MaxSod = 31 * SecondsPerHour + 63 * SecondsPerMin + 63;

  typedef struct packed {
    logic [YearW-1:0]   year_of_century;
    logic [MonthW-1:0]  month_number;
    logic [DayW-1:0]    day_of_month;
    logic [HourW-1:0]   hour_value;
    logic [MinuteW-1:0] minute_value;
    logic [SecondW-1:0] second_value;
  } dts_in_t;

  typedef struct packed {
    logic [ResultW-1:0] elapsed_seconds;
  } dts_out_t;

  typedef struct packed {
    logic signed [DaysW-1:0] days;
    logic [SodW-1:0]         sod;
  } dts_mid_t;

  // Days in the months that have fully elapsed, non-leap year.
  function automatic logic [8:0] days_before_month(input logic [MonthW-1:0] elapsed);
    logic [8:0] d;
    case (elapsed)
      4'd0:    d = 9'd0;
      4'd1:    d = 9'd31;
      4'd2:    d = 9'd59;
      4'd3:    d = 9'd90;
      4'd4:    d = 9'd120;
      4'd5:    d = 9'd151;
      4'd6:    d = 9'd181;
      4'd7:    d = 9'd212;
      4'd8:    d = 9'd243;
      4'd9:    d = 9'd273;
      4'd10:   d = 9'd304;
      4'd11:   d = 9'd334;
      default: d = 9'd365;
    endcase
    return d;
  endfunction

endpackage

// ===== src/dts_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Date-to-seconds input channel
// Valid/ready channel that carries one decoded date and time per beat.
// ----------------------------------------------------------------------------
interface dts_in_if;
  import dts_pkg::*;

  logic    valid;
  logic    ready;
  dts_in_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);

endinterface

// ===== src/dts_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Date-to-seconds output channel
// Valid/ready channel that carries one elapsed-seconds count per beat.
// ----------------------------------------------------------------------------
interface dts_out_if;
  import dts_pkg::*;

  logic     valid;
  logic     ready;
  dts_out_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);

endinterface

// ===== src/dts_day_count.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Date-to-seconds day count
// Closed-form day count since the epoch and seconds within the day.
// ----------------------------------------------------------------------------
module dts_day_count (
  input  dts_pkg::dts_in_t  item_i,
  output dts_pkg::dts_mid_t mid_o
);
  import dts_pkg::*;

  logic [YearW-1:0]  year;
  logic [MonthW-1:0] elapsed;
  logic [15:0]       year_days;
  logic [4:0]        leaps;
  logic [5:0]        quad;
  logic              leap_year;
  logic [8:0]        month_days;
  logic [DaysW-1:0]  days_sum;
  logic [SodW-1:0]   hour_sec;
  logic [SodW-1:0]   min_sec;

  assign year = item_i.year_of_century;

  // Leap years before this one; only the year 100 drops out below 128.
  assign quad = 6'((8'(year) + 8'd3) >> 2);
  always_comb begin
    if (year == '0) begin
      leaps = '0;
    end else if (32'(year) > CenturyYear) begin
      leaps = 5'(quad - 6'd1);
    end else begin
      leaps = 5'(quad);
    end
  end

  assign leap_year = (year[1:0] == 2'b00) && (32'(year) != CenturyYear);

  always_comb begin
    if (item_i.month_number == '0) begin
      elapsed = '0;
    end else if (32'(item_i.month_number) > MonthsPerYear) begin
      elapsed = MonthW'(MonthsPerYear);
    end else begin
      elapsed = item_i.month_number - MonthW'(1);
    end
  end

  assign month_days = days_before_month(elapsed);
  assign year_days  = 16'(year * 16'(DaysPerYear));

  assign days_sum = DaysW'(year_days) + DaysW'(leaps) + DaysW'(month_days)
                  + DaysW'((elapsed >= MonthW'(2)) && leap_year)
                  + DaysW'(item_i.day_of_month) - DaysW'(1);

  assign hour_sec = SodW'(item_i.hour_value * SodW'(SecondsPerHour));
  assign min_sec  = SodW'(item_i.minute_value * SodW'(SecondsPerMin));

  assign mid_o.days = signed'(days_sum);
  assign mid_o.sod  = hour_sec + min_sec + SodW'(item_i.second_value);

endmodule

// ===== src/date_time_to_seconds.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Date and time to seconds since 2000
// Converts a decoded calendar date and time of day into elapsed seconds.
// ----------------------------------------------------------------------------
// Each beat passes the input, day-count and result registers in that order.
// Throughput: one beat per cycle unless the result beat stalls; the constant
// multiply by 86400 and the seconds-of-day add lie between the day-count
// register and the result register.
// Reset clears all valid flags; no beat is held after reset.
module date_time_to_seconds (
  input  logic     clk_i,
  input  logic     rst_ni,
  dts_in_if.sink   in_i,
  dts_out_if.source out_o
);
  import dts_pkg::*;

  logic               advance;
  logic               s1_valid_q;
  dts_in_t            s1_item_q;
  logic               s2_valid_q;
  dts_mid_t           s2_mid_q;
  dts_mid_t           mid_d;
  logic               out_valid_q;
  logic [ResultW-1:0] out_data_q;
  logic [ResultW-1:0] out_data_d;
  logic [ResultW-1:0] days_ext;

  // The whole pipeline moves together whenever the result register is free.
  assign advance   = !out_valid_q || out_o.ready;
  assign in_i.ready = advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (advance) begin
      s1_valid_q  <= in_i.valid;
      s2_valid_q  <= s1_valid_q;
      out_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      s1_item_q  <= in_i.data;
      s2_mid_q   <= mid_d;
      out_data_q <= out_data_d;
    end
  end

  dts_day_count u_day_count (
    .item_i (s1_item_q),
    .mid_o  (mid_d)
  );

  assign days_ext   = ResultW'(s2_mid_q.days);
  assign out_data_d = ResultW'(days_ext * ResultW'(SecondsPerDay))
                    + ResultW'(s2_mid_q.sod);

  assign out_o.valid                = out_valid_q;
  assign out_o.data.elapsed_seconds = out_data_q;

  a_stall_holds_pipe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_o.ready) |=> ($stable(s2_mid_q) && $stable(s1_item_q)
                                       && $stable(s2_valid_q)))
    else $error("pipeline moved while the result beat was stalled");

  a_days_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s2_valid_q && s2_mid_q.days[DaysW-1]) |-> (s2_mid_q.days == '1))
    else $error("day count below minus one");

  a_sod_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_valid_q |-> (32'(s2_mid_q.sod) <= MaxSod))
    else $error("seconds of day out of range");

endmodule
